### hw/rtl/tegp_pkg.sv
package tegp_pkg;

    localparam int CW             = 13;
    localparam int PIX_W          = 32;
    localparam int MODE_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int JOBQ_DEPTH     = 4;
    localparam int JOBQ_PW        = 2;

    localparam logic [MODE_W-1:0] MODE_PACK16      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COPY32      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGB_TO_RGBA = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNSUPPORTED = 2'd3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [CW-1:0]     width;
        logic [CW-1:0]     height;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    // One request as classified by the front end.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CW-1:0]    x_main;
        logic [CW-1:0]    y;
        logic             left;
        logic             right;
        logic             flast;
    } job_t;

endpackage

### hw/rtl/tegp_ram.sv
module tegp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read and write to the same address return the old word.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/tegp_front.sv
module tegp_front #(
    parameter int MAX_WIDTH  = tegp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tegp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tegp_pkg::cfg_t             cfg,
    input  logic                       restart,
    input  logic                       push,
    output logic                       full,
    input  logic                       command,
    input  logic [tegp_pkg::PIX_W-1:0] pixel_bytes,
    input  logic                       q_full,
    output logic                       q_push,
    output tegp_pkg::job_t             q_job
);
    import tegp_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    localparam logic [1:0] PH_RECV  = 2'd0;
    localparam logic [1:0] PH_DRAIN = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW:0]   dcol_reg, dcol_next;
    logic          drow_reg, drow_next;

    logic          s1_valid_reg, s1_valid_next;
    job_t          s1_job_reg, s1_job_next;
    logic          s1_new_reg, s1_new_next;

    logic             enabled;
    logic             accept;
    logic             pixel_ok;
    logic             tick_ok;
    logic [CW:0]      w_plus1;
    logic [CW-1:0]    w_minus1;
    logic [CW:0]      sx;
    logic [PIX_W-1:0] conv;
    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_rd_addr;
    logic [PIX_W-1:0] ram_rd_data;

    assign enabled = (cfg.width != '0) && (cfg.height != '0)
                     && (32'(cfg.width) <= 32'(MAX_WIDTH))
                     && (32'(cfg.height) <= 32'(MAX_HEIGHT))
                     && (cfg.mode != MODE_UNSUPPORTED);

    assign w_plus1  = {1'b0, cfg.width} + {{CW{1'b0}}, 1'b1};
    assign w_minus1 = cfg.width - {{(CW-1){1'b0}}, 1'b1};

    assign full   = s1_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = s1_valid_reg && !q_full;

    assign pixel_ok = enabled && (command == CMD_PIXEL) && (phase_reg == PH_RECV)
                      && (col_reg < cfg.width) && (row_reg < cfg.height);
    assign tick_ok  = enabled && (command == CMD_TICK) && (phase_reg == PH_DRAIN)
                      && (dcol_reg <= w_plus1);

    always_comb
    begin
        case (cfg.mode)
            MODE_PACK16:      conv = {16'h0000, pixel_bytes[15:0]};
            MODE_RGB_TO_RGBA: conv = {ALPHA_OPAQUE, pixel_bytes[23:0]};
            default:          conv = pixel_bytes;
        endcase
    end

    // Drain column maps back to the nearest source column.
    always_comb
    begin
        if (dcol_reg == '0)
        begin
            sx = '0;
        end
        else if (dcol_reg == w_plus1)
        begin
            sx = {1'b0, w_minus1};
        end
        else
        begin
            sx = dcol_reg - {{CW{1'b0}}, 1'b1};
        end
    end

    assign ram_we      = accept && pixel_ok;
    assign ram_re      = accept && (pixel_ok || tick_ok);
    assign ram_rd_addr = pixel_ok ? AW'(col_reg) : AW'(sx);

    tegp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (AW'(col_reg)),
        .wr_data (conv),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        dcol_next     = dcol_reg;
        drow_next     = drow_reg;
        s1_valid_next = s1_valid_reg;
        s1_job_next   = s1_job_reg;
        s1_new_next   = s1_new_reg;

        if (q_push)
        begin
            s1_valid_next = 1'b0;
        end

        if (accept && pixel_ok)
        begin
            s1_valid_next      = 1'b1;
            s1_job_next.pix    = conv;
            s1_job_next.x_main = col_reg + {{(CW-1){1'b0}}, 1'b1};
            s1_job_next.y      = row_reg;
            s1_job_next.left   = (col_reg == '0);
            s1_job_next.right  = (col_reg == w_minus1);
            s1_job_next.flast  = 1'b0;
            s1_new_next        = (row_reg == '0);
            if (col_reg == w_minus1)
            begin
                col_next = '0;
                row_next = row_reg + {{(CW-1){1'b0}}, 1'b1};
                if (row_reg == cfg.height - {{(CW-1){1'b0}}, 1'b1})
                begin
                    phase_next = PH_DRAIN;
                end
            end
            else
            begin
                col_next = col_reg + {{(CW-1){1'b0}}, 1'b1};
            end
        end
        else if (accept && tick_ok)
        begin
            s1_valid_next      = 1'b1;
            s1_job_next.pix    = conv;
            s1_job_next.x_main = dcol_reg[CW-1:0];
            s1_job_next.y      = cfg.height + {{(CW-1){1'b0}}, drow_reg};
            s1_job_next.left   = 1'b0;
            s1_job_next.right  = 1'b0;
            s1_job_next.flast  = drow_reg && (dcol_reg == w_plus1);
            s1_new_next        = 1'b0;
            if (dcol_reg == w_plus1)
            begin
                dcol_next = '0;
                drow_next = 1'b1;
                if (drow_reg)
                begin
                    phase_next = PH_DONE;
                end
            end
            else
            begin
                dcol_next = dcol_reg + {{CW{1'b0}}, 1'b1};
            end
        end

        if (restart)
        begin
            phase_next = PH_RECV;
            col_next   = '0;
            row_next   = '0;
            dcol_next  = '0;
            drow_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RECV;
            col_reg      <= '0;
            row_reg      <= '0;
            dcol_reg     <= '0;
            drow_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            dcol_reg     <= dcol_next;
            drow_reg     <= drow_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_job_reg <= s1_job_next;
        s1_new_reg <= s1_new_next;
    end

    // Top row has no row above: take the incoming pixel instead of the store.
    always_comb
    begin
        q_job     = s1_job_reg;
        q_job.pix = s1_new_reg ? s1_job_reg.pix : ram_rd_data;
    end

endmodule

### hw/rtl/tegp_queue.sv
module tegp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  tegp_pkg::job_t wr_job,
    input  logic           rd,
    output tegp_pkg::job_t head,
    output logic           q_full,
    output logic           q_empty
);
    import tegp_pkg::*;

    job_t                 slots [JOBQ_DEPTH];
    logic [JOBQ_PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [JOBQ_PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [JOBQ_PW:0]     count_reg, count_next;

    assign q_full  = (count_reg == (JOBQ_PW+1)'(JOBQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = wr_ptr_reg + {{(JOBQ_PW-1){1'b0}}, 1'b1};
        end
        if (rd)
        begin
            rd_ptr_next = rd_ptr_reg + {{(JOBQ_PW-1){1'b0}}, 1'b1};
        end
        if (wr && !rd)
        begin
            count_next = count_reg + {{JOBQ_PW{1'b0}}, 1'b1};
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - {{JOBQ_PW{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### hw/rtl/tegp_back.sv
module tegp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tegp_pkg::CW-1:0]    image_width,
    input  tegp_pkg::job_t             head,
    input  logic                       q_empty,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic [tegp_pkg::PIX_W-1:0] out_pixel,
    output logic [tegp_pkg::CW-1:0]    padded_x,
    output logic [tegp_pkg::CW-1:0]    padded_y,
    output logic                       run_last,
    output logic                       frame_last
);
    import tegp_pkg::*;

    localparam logic [1:0] ST_LEFT  = 2'd0;
    localparam logic [1:0] ST_MAIN  = 2'd1;
    localparam logic [1:0] ST_RIGHT = 2'd2;

    logic [1:0]       step_reg, step_next;
    logic [1:0]       step_eff;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] pix_reg;
    logic [CW-1:0]    x_reg, x_next;
    logic [CW-1:0]    y_reg;
    logic             rlast_reg, rlast_next;
    logic             flast_reg;
    logic             load;
    logic             is_last;

    assign load = !q_empty && (!out_valid_reg || pop);

    // Skip the left gutter step for jobs that have none.
    assign step_eff = ((step_reg == ST_LEFT) && !head.left) ? ST_MAIN : step_reg;
    assign is_last  = (step_eff == ST_RIGHT) || ((step_eff == ST_MAIN) && !head.right);
    assign q_pop    = load && is_last;

    always_comb
    begin
        case (step_eff)
            ST_LEFT:  x_next = '0;
            ST_MAIN:  x_next = head.x_main;
            default:  x_next = image_width + {{(CW-1){1'b0}}, 1'b1};
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        rlast_next     = rlast_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            rlast_next     = is_last;
            step_next      = is_last ? ST_LEFT : step_eff + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_LEFT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg   <= head.pix;
            x_reg     <= x_next;
            y_reg     <= head.y;
            rlast_reg <= rlast_next;
            flast_reg <= head.flast && is_last;
        end
    end

    assign empty      = !out_valid_reg;
    assign out_pixel  = pix_reg;
    assign padded_x   = x_reg;
    assign padded_y   = y_reg;
    assign run_last   = rlast_reg;
    assign frame_last = flast_reg;

endmodule

### hw/rtl/texture_edge_gutter_padder.sv
// Channel   | Handshake           | Payload
// ----------+---------------------+---------------------------------------------
// input     | push / full         | command, pixel_bytes
// result    | empty / pop         | out_pixel, padded_x, padded_y, run_last,
//           |                     | frame_last
// config    | cfg_write           | cfg_index, cfg_data
//
// One request is taken per cycle while full is low; a pixel at a row edge yields two or
// three results, and the result side delivers one per cycle while pop is high, so row
// edges set the rate. The first result reaches the ports through the line store read,
// the job queue and the output register. A four-entry job queue sits between the two sides.
// Reset is asynchronous; the line store is not cleared and is always written
// before it is read within a frame. full rises only when the job queue backs up.
module texture_edge_gutter_padder #(
    parameter int MAX_WIDTH  = tegp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tegp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           command,
    input  logic [tegp_pkg::PIX_W-1:0]     pixel_bytes,
    output logic                           empty,
    input  logic                           pop,
    output logic [tegp_pkg::PIX_W-1:0]     out_pixel,
    output logic [tegp_pkg::CW-1:0]        padded_x,
    output logic [tegp_pkg::CW-1:0]        padded_y,
    output logic                           run_last,
    output logic                           frame_last,
    input  logic                           cfg_write,
    input  logic [tegp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tegp_pkg::CW-1:0]        cfg_data
);
    import tegp_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  restart;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    job_t  q_in;
    job_t  q_head;

    // Any write to a listed register restarts the frame.
    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    cfg_next.width = cfg_data;
                    restart        = 1'b1;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    cfg_next.height = cfg_data;
                    restart         = 1'b1;
                end
                CFG_PIXEL_MODE:
                begin
                    cfg_next.mode = cfg_data[MODE_W-1:0];
                    restart       = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= {{(CW-1){1'b0}}, 1'b1};
            cfg_reg.height <= {{(CW-1){1'b0}}, 1'b1};
            cfg_reg.mode   <= MODE_COPY32;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tegp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .restart     (restart),
        .push        (push),
        .full        (full),
        .command     (command),
        .pixel_bytes (pixel_bytes),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_in)
    );

    tegp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_job  (q_in),
        .rd      (q_pop),
        .head    (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    tegp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_width (cfg_reg.width),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_pixel   (out_pixel),
        .padded_x    (padded_x),
        .padded_y    (padded_y),
        .run_last    (run_last),
        .frame_last  (frame_last)
    );

endmodule
